// ----- rtl/ort_pkg.sv -----
// Shared types and codes for the outstanding request tracker.
`timescale 1ns / 1ps

package ort_pkg;

  localparam int SEG_W   = 6;
  localparam int IFACE_W = 8;
  localparam int RID_W   = 32;
  localparam int PEND_W  = 7;

  // command codes
  localparam logic CMD_ISSUE    = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  // response status codes
  localparam logic STATUS_OKAY  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic               command;
    logic [IFACE_W-1:0] interface_id;
    logic [RID_W-1:0]   request_id;
    logic               write_op;
    logic [SEG_W-1:0]   segment_count;
    logic [SEG_W-1:0]   slot_index;
    logic               segment_ok;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [SEG_W-1:0]   granted_slot;
    logic               refused_full;
    logic               response_valid;
    logic [IFACE_W-1:0] response_interface;
    logic [RID_W-1:0]   response_id;
    logic               response_write;
    logic               response_status;
    logic               completion_fault;
    logic [PEND_W-1:0]  pending_count;
    logic               below_half;
  } out_item_t;

  // one scoreboard entry
  typedef struct packed {
    logic [SEG_W-1:0]   remaining;
    logic [IFACE_W-1:0] interface_id;
    logic [RID_W-1:0]   request_id;
    logic               write_op;
    logic               error;
  } slot_entry_t;

  // free ring update strobes
  typedef struct packed {
    logic pop;
    logic push;
  } ring_ctl_t;

endpackage

// ----- rtl/ort_chan_if.sv -----
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps

interface ort_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ort_ring.sv -----
// Free slot ring: index memory with head/tail pointers and free count.
`timescale 1ns / 1ps

module ort_ring #(
  parameter int SLOT_COUNT = 64,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int PTR_W = IDX_W + 1,
  localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  ort_pkg::ring_ctl_t ctl,
  input  logic [IDX_W-1:0] push_slot,
  output logic [IDX_W-1:0] head_slot,
  output logic [CNT_W-1:0] free_cnt
);

  logic [IDX_W-1:0]      ring_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [PTR_W-1:0]      head_next;
  logic [PTR_W-1:0]      tail_next;
  logic [IDX_W-1:0]      head_idx;
  logic [IDX_W-1:0]      tail_idx;
  logic [PTR_W:0]        diff_w;
  logic [IDX_W-1:0]      rd_data;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_vld;

  // pointers run modulo twice the pool; memory index is modulo the pool
  always_comb begin
    head_idx = (head >= PTR_W'(SLOT_COUNT)) ? IDX_W'(head - PTR_W'(SLOT_COUNT))
                                             : IDX_W'(head);
    tail_idx = (tail >= PTR_W'(SLOT_COUNT)) ? IDX_W'(tail - PTR_W'(SLOT_COUNT))
                                             : IDX_W'(tail);
    head_next = (head == PTR_W'(2 * SLOT_COUNT - 1)) ? '0 : head + 1'b1;
    tail_next = (tail == PTR_W'(2 * SLOT_COUNT - 1)) ? '0 : tail + 1'b1;
  end

  // free count = tail - head modulo twice the pool
  always_comb begin
    if (tail >= head) begin
      diff_w = {1'b0, tail} - {1'b0, head};
    end else begin
      diff_w = {1'b0, tail} + (PTR_W + 1)'(2 * SLOT_COUNT) - {1'b0, head};
    end
    free_cnt = CNT_W'(diff_w);
  end

  // pointers and written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= PTR_W'(SLOT_COUNT);
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (ctl.pop) begin
        head <= head_next;
      end
      if (ctl.push) begin
        tail              <= tail_next;
        written[tail_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= written[head_idx];
      end
    end
  end

  // ring memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ring_mem[tail_idx] <= push_slot;
    end
    if (rd_en) begin
      rd_data <= ring_mem[head_idx];
      rd_idx  <= head_idx;
    end
  end

  // an entry never written holds its own index
  assign head_slot = rd_vld ? rd_data : rd_idx;

endmodule

// ----- rtl/ort_slots.sv -----
// Per-slot scoreboard memory with written flags for the idle reset value.
`timescale 1ns / 1ps

module ort_slots #(
  parameter int SLOT_COUNT = 64,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  ort_pkg::slot_entry_t wr_data,
  output ort_pkg::slot_entry_t rd_entry
);

  ort_pkg::slot_entry_t  slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written;
  ort_pkg::slot_entry_t  rd_data;
  logic                  rd_vld;

  // written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= written[rd_addr];
      end
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= slot_mem[rd_addr];
    end
  end

  // unwritten slot reads as idle
  always_comb begin
    rd_entry = rd_data;
    if (!rd_vld) begin
      rd_entry.remaining = '0;
    end
  end

endmodule

// ----- rtl/outstanding_request_tracker_unit.sv -----
// The accepted beat and the memory read are registered; the update then loads the result into the output register.
// A new item is taken only in the idle state, after the read then write-back of the ring and slot memories.
// The next item is taken while a result still waits; the update stalls only when it is not taken.
// Reset: synchronous; pool all free, every slot idle, no result pending. No clearing pass.
// Latency and throughput do not depend on the parameters.
`timescale 1ns / 1ps

module outstanding_request_tracker_unit #(
  parameter int SLOT_COUNT   = 64,
  parameter int MAX_SEGMENTS = 22
) (
  input logic      clk,
  input logic      rst,
  ort_chan_if.sink req,
  ort_chan_if.source rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int SIX_W = (IDX_W > ort_pkg::SEG_W) ? IDX_W : ort_pkg::SEG_W;
  localparam int PND_W = (CNT_W > ort_pkg::PEND_W) ? CNT_W : ort_pkg::PEND_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t               state;
  ort_pkg::in_item_t    item;
  logic                 in_range;
  ort_pkg::out_item_t   out_next;
  ort_pkg::ring_ctl_t   ring_req;
  ort_pkg::ring_ctl_t   ring_ctl;
  ort_pkg::slot_entry_t slot_rd;
  ort_pkg::slot_entry_t slot_wdata;
  logic                 slot_we;
  logic [IDX_W-1:0]     head_slot;
  logic [CNT_W-1:0]     free_cnt;
  logic [CNT_W-1:0]     free_after;
  logic [CNT_W-1:0]     pending;
  logic [PND_W-1:0]     pending_w;
  logic [SIX_W-1:0]     slot_w;
  logic [SIX_W:0]       sidx_w;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     item_addr;
  logic [ort_pkg::SEG_W-1:0] seg_left;
  logic                 take;
  logic                 fire;

  // handshake
  assign req.ready = (state == S_IDLE);
  assign take      = req.valid && req.ready;
  assign fire      = (state == S_EXEC) && (!rsp.valid || rsp.ready);

  // incoming slot index, range checked against the pool
  assign sidx_w  = (SIX_W + 1)'(req.payload.slot_index);
  assign rd_addr = IDX_W'(sidx_w);
  assign item_addr = IDX_W'(item.slot_index);

  ort_ring #(.SLOT_COUNT(SLOT_COUNT)) u_ring (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (take),
    .ctl       (ring_ctl),
    .push_slot (item_addr),
    .head_slot (head_slot),
    .free_cnt  (free_cnt)
  );

  ort_slots #(.SLOT_COUNT(SLOT_COUNT)) u_slots (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (take),
    .rd_addr  (rd_addr),
    .wr_en    (fire && slot_we),
    .wr_addr  (ring_req.pop ? head_slot : item_addr),
    .wr_data  (slot_wdata),
    .rd_entry (slot_rd)
  );

  assign ring_ctl.pop  = fire && ring_req.pop;
  assign ring_ctl.push = fire && ring_req.push;

  // decide the item from the read data and build the result beat
  always_comb begin
    out_next   = '0;
    ring_req   = '0;
    slot_we    = 1'b0;
    slot_wdata = slot_rd;
    seg_left   = slot_rd.remaining - 1'b1;
    slot_w     = SIX_W'(head_slot);
    if (item.command == ort_pkg::CMD_ISSUE) begin
      if (free_cnt == '0) begin
        out_next.refused_full = 1'b1;
      end else if (item.segment_count == '0 ||
                   item.segment_count > ort_pkg::SEG_W'(MAX_SEGMENTS)) begin
        out_next.response_valid     = 1'b1;
        out_next.response_interface = item.interface_id;
        out_next.response_id        = item.request_id;
        out_next.response_write     = item.write_op;
        out_next.response_status    = ort_pkg::STATUS_ERROR;
      end else begin
        ring_req.pop            = 1'b1;
        slot_we                 = 1'b1;
        slot_wdata.remaining    = item.segment_count;
        slot_wdata.interface_id = item.interface_id;
        slot_wdata.request_id   = item.request_id;
        slot_wdata.write_op     = item.write_op;
        slot_wdata.error        = ort_pkg::STATUS_OKAY;
        out_next.accepted       = 1'b1;
        out_next.granted_slot   = slot_w[ort_pkg::SEG_W-1:0];
      end
    end else begin
      if (!in_range || slot_rd.remaining == '0) begin
        out_next.completion_fault = 1'b1;
      end else begin
        slot_we              = 1'b1;
        slot_wdata.remaining = seg_left;
        slot_wdata.error     = slot_rd.error | ~item.segment_ok;
        if (seg_left == '0) begin
          ring_req.push               = 1'b1;
          out_next.response_valid     = 1'b1;
          out_next.response_interface = slot_rd.interface_id;
          out_next.response_id        = slot_rd.request_id;
          out_next.response_write     = slot_rd.write_op;
          out_next.response_status    = slot_wdata.error;
        end
      end
    end
    free_after = free_cnt - CNT_W'(ring_req.pop) + CNT_W'(ring_req.push);
    pending    = CNT_W'(SLOT_COUNT) - free_after;
    pending_w  = PND_W'(pending);
    out_next.pending_count = pending_w[ort_pkg::PEND_W-1:0];
    out_next.below_half    = (pending < CNT_W'(SLOT_COUNT / 2));
  end

  // sequencer, item register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      // a taken beat clears valid unless a new one is loaded this cycle
      if (rsp.valid && rsp.ready && !fire) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            item     <= req.payload;
            in_range <= (sidx_w < (SIX_W + 1)'(SLOT_COUNT));
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            rsp.payload <= out_next;
            rsp.valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= CNT_W'(SLOT_COUNT))
    else $error("free count above pool size");

  a_outcome_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $onehot0({rsp.payload.accepted, rsp.payload.refused_full,
                            rsp.payload.response_valid, rsp.payload.completion_fault}))
    else $error("result beat carries more than one outcome");

  a_ring_one_op: assert property (@(posedge clk) disable iff (rst)
    !(ring_ctl.pop && ring_ctl.push))
    else $error("ring pop and push in one cycle");

  a_update_after_read: assert property (@(posedge clk) disable iff (rst)
    (ring_ctl.pop || ring_ctl.push) |-> (state == S_EXEC))
    else $error("ring update outside the update cycle");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the outstanding request tracker: directed and random issue/completion traffic.
module testbench;

  localparam int SLOTS    = 64;
  localparam int MAX_SEGS = 22;
  localparam int ITEMS    = 1550;

  // receiver back-pressure styles
  typedef enum int {RX_STREAM, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  ort_chan_if #(.T(ort_pkg::in_item_t))  req_if ();
  ort_chan_if #(.T(ort_pkg::out_item_t)) rsp_if ();

  outstanding_request_tracker_unit #(
    .SLOT_COUNT  (SLOTS),
    .MAX_SEGMENTS(MAX_SEGS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Shadow of the slot pool: free ring, per-slot scoreboard, expected result beats.
  class tracker_shadow;
    logic [ort_pkg::SEG_W-1:0] free_ring [SLOTS];
    logic [6:0]                free_head;
    logic [6:0]                free_tail;
    ort_pkg::slot_entry_t      slots [SLOTS];
    ort_pkg::out_item_t        awaited_results [$];
    int                        mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        free_ring[i] = ort_pkg::SEG_W'(i);
        slots[i] = '0;
      end
      free_head = '0;
      free_tail = 7'(SLOTS);
      mismatches = 0;
    endfunction

    function int in_use();
      logic [6:0] free_n;
      free_n = free_tail - free_head;
      return SLOTS - int'(free_n);
    endfunction

    // random slot that still has segments outstanding, -1 if none
    function int any_live_slot();
      int live [$];
      for (int i = 0; i < SLOTS; i++) begin
        if (slots[i].remaining != 0) live.push_back(i);
      end
      if (live.size() == 0) return -1;
      return live[$urandom_range(live.size() - 1)];
    endfunction

    // apply one accepted request beat and queue the result it must produce
    function void take_request(ort_pkg::in_item_t it);
      ort_pkg::out_item_t        e;
      logic [ort_pkg::SEG_W-1:0] s;
      int                        busy;
      e = '0;
      if (it.command == ort_pkg::CMD_ISSUE) begin
        if (in_use() == SLOTS) begin
          e.refused_full = 1'b1;
        end else if (it.segment_count == 0 || it.segment_count > MAX_SEGS) begin
          // bad segment count: immediate error response, no slot taken
          e.response_valid     = 1'b1;
          e.response_interface = it.interface_id;
          e.response_id        = it.request_id;
          e.response_write     = it.write_op;
          e.response_status    = ort_pkg::STATUS_ERROR;
        end else begin
          s = free_ring[free_head % SLOTS];
          free_head = free_head + 7'd1;
          slots[s].remaining    = it.segment_count;
          slots[s].interface_id = it.interface_id;
          slots[s].request_id   = it.request_id;
          slots[s].write_op     = it.write_op;
          slots[s].error        = ort_pkg::STATUS_OKAY;
          e.accepted     = 1'b1;
          e.granted_slot = s;
        end
      end else begin
        s = it.slot_index;
        if (slots[s].remaining == 0) begin
          e.completion_fault = 1'b1;
        end else begin
          if (!it.segment_ok) slots[s].error = ort_pkg::STATUS_ERROR;
          slots[s].remaining = slots[s].remaining - 1'b1;
          // last segment: respond and return the slot to the ring
          if (slots[s].remaining == 0) begin
            e.response_valid     = 1'b1;
            e.response_interface = slots[s].interface_id;
            e.response_id        = slots[s].request_id;
            e.response_write     = slots[s].write_op;
            e.response_status    = slots[s].error;
            free_ring[free_tail % SLOTS] = s;
            free_tail = free_tail + 7'd1;
          end
        end
      end
      busy = in_use();
      e.pending_count = ort_pkg::PEND_W'(busy);
      e.below_half    = (busy < SLOTS / 2);
      awaited_results.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(ort_pkg::out_item_t got);
      ort_pkg::out_item_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("granted_slot", want.granted_slot, got.granted_slot);
      compare_field("refused_full", want.refused_full, got.refused_full);
      compare_field("response_valid", want.response_valid, got.response_valid);
      compare_field("response_interface", want.response_interface, got.response_interface);
      compare_field("response_id", want.response_id, got.response_id);
      compare_field("response_write", want.response_write, got.response_write);
      compare_field("response_status", want.response_status, got.response_status);
      compare_field("completion_fault", want.completion_fault, got.completion_fault);
      compare_field("pending_count", want.pending_count, got.pending_count);
      compare_field("below_half", want.below_half, got.below_half);
    endfunction
  endclass

  tracker_shadow tracker = new();

  int       occupancy_goal = 16;
  int       burst_left     = 0;
  rx_mode_t stall_mode     = RX_STREAM;
  int       stall_left     = 0;
  int       ready_cycle    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fully random beat; every field gets a value.
  function automatic ort_pkg::in_item_t noise_item();
    ort_pkg::in_item_t it;
    it.command       = 1'($urandom_range(1));
    it.interface_id  = 8'($urandom);
    it.request_id    = $urandom;
    it.write_op      = 1'($urandom_range(1));
    it.segment_count = 6'($urandom);
    it.slot_index    = 6'($urandom);
    it.segment_ok    = 1'($urandom_range(1));
    return it;
  endfunction

  // Directed issue; the completion fields stay random.
  function automatic ort_pkg::in_item_t issue_item(logic [7:0] iface, logic [31:0] rid,
                                                   logic wr, logic [5:0] segs);
    ort_pkg::in_item_t it;
    it               = noise_item();
    it.command       = ort_pkg::CMD_ISSUE;
    it.interface_id  = iface;
    it.request_id    = rid;
    it.write_op      = wr;
    it.segment_count = segs;
    return it;
  endfunction

  // Directed completion; the issue fields stay random.
  function automatic ort_pkg::in_item_t complete_item(logic [5:0] slot, logic ok);
    ort_pkg::in_item_t it;
    it            = noise_item();
    it.command    = ort_pkg::CMD_COMPLETE;
    it.slot_index = slot;
    it.segment_ok = ok;
    return it;
  endfunction

  // Mostly well-formed traffic steered toward an occupancy goal, with some noise.
  function automatic ort_pkg::in_item_t random_request();
    ort_pkg::in_item_t it;
    int                live;
    int                roll;
    logic              want_issue;
    it = noise_item();
    if ($urandom_range(99) < 5) return it;
    live = tracker.any_live_slot();
    roll = $urandom_range(99);
    want_issue = (tracker.in_use() < occupancy_goal) ? (roll < 75) : (roll < 25);
    if (live < 0 || want_issue) begin
      it.command = ort_pkg::CMD_ISSUE;
      roll = $urandom_range(99);
      if (roll < 6) begin
        it.segment_count = '0;
      end else if (roll < 12) begin
        it.segment_count = 6'($urandom_range(63, MAX_SEGS + 1));
      end else if (roll < 75) begin
        it.segment_count = 6'($urandom_range(3, 1));
      end else begin
        it.segment_count = 6'($urandom_range(MAX_SEGS, 1));
      end
    end else begin
      it.command    = ort_pkg::CMD_COMPLETE;
      it.slot_index = 6'(live);
      it.segment_ok = ($urandom_range(11) != 0);
    end
    return it;
  endfunction

  // Present one beat, hold it until taken, then either keep streaming or pause.
  task automatic send_request(input ort_pkg::in_item_t it, input bit is_last);
    req_if.payload <= it;
    req_if.valid   <= 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    tracker.take_request(it);
    if (is_last || burst_left == 0) begin
      req_if.valid <= 1'b0;
      if (!is_last) begin
        repeat ($urandom_range(12, 1)) @(posedge clk);
        burst_left = ($urandom_range(9) == 0) ? int'($urandom_range(200, 60))
                                               : int'($urandom_range(40));
      end
    end else begin
      burst_left--;
    end
  endtask

  // Result side: check taken beats, drive ready from the current stall style.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) tracker.check_response(rsp_if.payload);
    ready_cycle <= ready_cycle + 1;
    if (stall_left == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(3));
      stall_left <= int'($urandom_range(250, 30));
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RX_STREAM:   rsp_if.ready <= 1'b1;
      RX_LIGHT:    rsp_if.ready <= ($urandom_range(3) != 0);
      RX_HEAVY:    rsp_if.ready <= ($urandom_range(3) == 0);
      default:     rsp_if.ready <= (ready_cycle % 3 == 0);
    endcase
  end

  initial begin
    ort_pkg::in_item_t plan [$];
    rst            <= 1'b1;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;

    // idle-slot completions, bad segment counts, field extremes, sticky error
    plan.push_back(complete_item(6'd0, 1'b1));
    plan.push_back(complete_item(6'd63, 1'b0));
    plan.push_back(issue_item(8'hff, 32'hffff_ffff, 1'b1, 6'd0));
    plan.push_back(issue_item(8'h00, 32'h0, 1'b0, 6'(MAX_SEGS + 1)));
    plan.push_back(issue_item(8'ha5, $urandom, 1'b1, 6'd63));
    plan.push_back(issue_item(8'h00, 32'h0, 1'b0, 6'd1));
    plan.push_back(issue_item(8'hff, 32'hffff_ffff, 1'b1, 6'(MAX_SEGS)));
    plan.push_back(issue_item(8'($urandom), $urandom, 1'b0, 6'd2));
    plan.push_back(complete_item(6'd0, 1'b1));
    plan.push_back(complete_item(6'd0, 1'b1));
    plan.push_back(complete_item(6'd2, 1'b0));
    plan.push_back(complete_item(6'd2, 1'b1));
    plan.push_back(issue_item(8'($urandom), $urandom, 1'b1, 6'd1));
    plan.push_back(complete_item(6'd3, 1'b0));
    plan.push_back(complete_item(6'd1, 1'b0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    burst_left = 20;

    for (int n = 0; n < ITEMS; n++) begin
      // move the occupancy goal now and then; full pool and the half mark get extra weight
      if (n % 150 == 0) begin
        case ($urandom_range(6))
          0:       occupancy_goal = 0;
          1:       occupancy_goal = 16;
          2:       occupancy_goal = SLOTS / 2 - 1;
          3:       occupancy_goal = SLOTS / 2 + 1;
          default: occupancy_goal = SLOTS;
        endcase
      end
      send_request((n < plan.size()) ? plan[n] : random_request(), n == ITEMS - 1);
    end

    // drain, then wait for stray beats
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
